// File: src/ctsi_pkg.sv
// Shared types, constants and the vertex table of the tetrahedral source index core.
package ctsi_pkg;

  localparam int VOX_W      = 36;
  localparam int COEF_W     = 32;
  localparam int SLOT_W     = 6;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int N_CFG      = 6;
  localparam int N_TET      = 5;
  localparam int TET_W      = 3;
  localparam int N_WORD     = 12;
  localparam int N_MAT      = 9;
  localparam int ORG_BASE   = 9;
  localparam int TABLE_DEPTH = 60;
  localparam int FRAC_W     = 28;
  localparam int ORG_FRAC_W = 16;
  localparam longint Q_ONE  = 64'sd268435456;
  localparam longint EPS_Q  = 64'sd2684;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DST_X = 3'd0,
    CFG_DST_Y = 3'd1,
    CFG_DST_Z = 3'd2,
    CFG_SRC_X = 3'd3,
    CFG_SRC_Y = 3'd4,
    CFG_SRC_Z = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_MAP  = 1'b1
  } req_t;

  typedef struct packed {
    logic                     req_type;
    logic [SLOT_W-1:0]        coef_slot;
    logic signed [COEF_W-1:0] coef_value;
    logic [VOX_W-1:0]         dst_voxel;
  } in_t;

  typedef struct packed {
    logic [VOX_W-1:0] dst_index;
    logic [VOX_W-1:0] src_index;
    logic             inside_res;
  } out_t;

  typedef logic [3:0][2:0] tet_verts_t;

  // Width of coord*2^16 - origin, signed.
  function automatic int diff_width(input int cw);
    return ((cw + ORG_FRAC_W > 31) ? cw + ORG_FRAC_W : 31) + 2;
  endfunction

  // Width of one barycentric weight in Q.28, signed.
  function automatic int lam_width(input int cw);
    return diff_width(cw) + 20;
  endfunction

  // Cube corners of each tetrahedron: bit 0 = x, bit 1 = y, bit 2 = z.
  function automatic tet_verts_t tet_verts(input logic [TET_W-1:0] t);
    tet_verts_t v;
    case (t)
      3'd0:    v = {3'd7, 3'd4, 3'd2, 3'd1};
      3'd1:    v = {3'd7, 3'd6, 3'd4, 3'd2};
      3'd2:    v = {3'd7, 3'd5, 3'd4, 3'd1};
      3'd3:    v = {3'd7, 3'd3, 3'd2, 3'd1};
      3'd4:    v = {3'd4, 3'd2, 3'd1, 3'd0};
      default: v = {3'd7, 3'd4, 3'd2, 3'd1};
    endcase
    return v;
  endfunction

endpackage

// File: src/ctsi_div.sv
// Pipelined restoring divider: one quotient bit per stage, side data travels along.
module ctsi_div #(
  parameter int NUM_W  = 36,
  parameter int DEN_W  = 13,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic [NUM_W-1:0]  word_r [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];
  logic              vld_r  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [NUM_W-1:0]  word_in;
    logic [DEN_W-1:0]  rem_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  word_nxt;

    if (i == 0) begin : g_first
      assign word_in = in_num;
      assign rem_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign word_in = word_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // shift in the next dividend bit, subtract where it fits
    always_comb begin
      trial    = {rem_in, word_in[NUM_W-1]};
      ge       = (trial >= {1'b0, in_den});
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, in_den}) : DEN_W'(trial);
      word_nxt = {word_in[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        word_r[i] <= word_nxt;
        rem_r[i]  <= rem_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = word_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

// File: src/ctsi_tab.sv
// Tetrahedron word store: one bank per word position, five tetrahedra deep.
module ctsi_tab (
  input  logic                                clk,
  input  logic                                we,
  input  logic [ctsi_pkg::SLOT_W-1:0]         slot,
  input  logic [ctsi_pkg::COEF_W-1:0]         wdata,
  input  logic [ctsi_pkg::TET_W-1:0]          rd_tet,
  output logic [ctsi_pkg::COEF_W-1:0]         w0 [ctsi_pkg::N_WORD],
  output logic [ctsi_pkg::COEF_W-1:0]         wt [ctsi_pkg::N_WORD]
);

  logic [ctsi_pkg::TET_W-1:0]  tet_sel;
  logic [ctsi_pkg::SLOT_W-1:0] base;
  logic [3:0]                  k_sel;
  logic                        slot_ok;

  // split slot into tetrahedron and word position
  always_comb begin
    if (slot >= 6'd48) begin
      tet_sel = 3'd4;
      base    = 6'd48;
    end else if (slot >= 6'd36) begin
      tet_sel = 3'd3;
      base    = 6'd36;
    end else if (slot >= 6'd24) begin
      tet_sel = 3'd2;
      base    = 6'd24;
    end else if (slot >= 6'd12) begin
      tet_sel = 3'd1;
      base    = 6'd12;
    end else begin
      tet_sel = 3'd0;
      base    = 6'd0;
    end
    k_sel   = 4'(slot - base);
    slot_ok = (slot < 6'(ctsi_pkg::TABLE_DEPTH));
  end

  for (genvar k = 0; k < ctsi_pkg::N_WORD; k++) begin : g_bank
    logic [ctsi_pkg::COEF_W-1:0] ent_r [ctsi_pkg::N_TET];

    always_ff @(posedge clk) begin
      if (we && slot_ok && (k_sel == 4'(k))) begin
        ent_r[tet_sel] <= wdata;
      end
    end

    assign w0[k] = ent_r[0];
    assign wt[k] = ent_r[rd_tet];
  end

endmodule

// File: src/ctsi_bary.sv
// One barycentric pass: offset, nine products, row sums, fourth weight; four stages.
module ctsi_bary #(
  parameter int CW     = 12,
  parameter int SIDE_W = 1
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [CW-1:0]                                 in_c [3],
  input  logic [ctsi_pkg::COEF_W-1:0]                   in_w [ctsi_pkg::N_WORD],
  input  logic [SIDE_W-1:0]                             in_side,
  output logic                                          out_valid,
  output logic signed [ctsi_pkg::lam_width(CW)-1:0]     out_lam [4],
  output logic [SIDE_W-1:0]                             out_side
);

  localparam int DW = ctsi_pkg::diff_width(CW);
  localparam int PW = DW + ctsi_pkg::COEF_W;
  localparam int LW = ctsi_pkg::lam_width(CW);

  logic signed [DW-1:0]                 d_nxt [3];
  logic signed [DW-1:0]                 d_r   [3];
  logic signed [ctsi_pkg::COEF_W-1:0]   m_r   [ctsi_pkg::N_MAT];
  logic signed [PW-1:0]                 p_nxt [ctsi_pkg::N_MAT];
  logic signed [PW-1:0]                 p_r   [ctsi_pkg::N_MAT];
  logic signed [PW+1:0]                 row_sum [3];
  logic signed [LW-1:0]                 lam_nxt [3];
  logic signed [LW-1:0]                 lam_r   [3];
  logic [SIDE_W-1:0]                    side1_r, side2_r, side3_r;
  logic                                 vld1_r, vld2_r, vld3_r;

  // coord - origin, exact in Q16.16
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_nxt[j] = DW'($signed({1'b0, in_c[j], 16'b0}))
               - DW'($signed(in_w[ctsi_pkg::ORG_BASE + j]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_nxt[3*i+j] = PW'(d_r[j]) * PW'(m_r[3*i+j]);
      end
    end
  end

  // floor of the full sum down to Q.28
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = (PW+2)'(p_r[3*i]) + (PW+2)'(p_r[3*i+1]) + (PW+2)'(p_r[3*i+2]);
      lam_nxt[i] = LW'(row_sum[i] >>> ctsi_pkg::ORG_FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1_r    <= in_valid;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      out_valid <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        d_r[j] <= d_nxt[j];
      end
      for (int n = 0; n < ctsi_pkg::N_MAT; n++) begin
        m_r[n] <= $signed(in_w[n]);
        p_r[n] <= p_nxt[n];
      end
      for (int i = 0; i < 3; i++) begin
        lam_r[i]   <= lam_nxt[i];
        out_lam[i] <= lam_r[i];
      end
      out_lam[3] <= LW'(ctsi_pkg::Q_ONE) - lam_r[0] - lam_r[1] - lam_r[2];
      side1_r  <= in_side;
      side2_r  <= side1_r;
      side3_r  <= side2_r;
      out_side <= side3_r;
    end
  end

endmodule

// File: src/cube_tetrahedral_source_index_core.sv
// Path of a map word: 3 x 36 divider stages, two 4-stage weight passes, tetrahedron
// pick, 3 index stages, output register. One map word per cycle while the skid
// register is empty. A load word is taken once no map word sits ahead of the second
// table read.
// Reset (synchronous, rst_n low): pipeline and output empty, size registers 1,
// tetrahedron words undefined until loaded.
module cube_tetrahedral_source_index_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ctsi_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ctsi_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [ctsi_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ctsi_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int CB       = COORD_BITS;
  localparam int EW       = CB + 1;
  localparam int VW       = ctsi_pkg::VOX_W;
  localparam int LW       = ctsi_pkg::lam_width(CB);
  localparam int SW       = LW + 2;
  localparam int S1W      = VW + 3 * CB;
  localparam int AW       = CB + 2 * EW + 1;
  localparam int PEND_MAX = 3 * VW + 5;
  localparam int PEND_W   = $clog2(PEND_MAX + 1);

  logic [ctsi_pkg::CFG_W-1:0] cfg_r [ctsi_pkg::N_CFG];
  logic [EW-1:0]              ds [3];
  logic [EW-1:0]              ss [3];

  function automatic logic [EW-1:0] eff_size(input logic [ctsi_pkg::CFG_W-1:0] v);
    logic [EW-1:0] lim;
    lim = EW'(1) << CB;
    if (v == '0) begin
      return EW'(1);
    end else if (18'(v) > 18'(lim)) begin
      return lim;
    end
    return EW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctsi_pkg::N_CFG; i++) begin
        cfg_r[i] <= ctsi_pkg::CFG_W'(1);
      end
    end else if (cfg_we && (cfg_idx < ctsi_pkg::CFG_IDX_W'(ctsi_pkg::N_CFG))) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  always_comb begin
    ds[0] = eff_size(cfg_r[ctsi_pkg::CFG_DST_X]);
    ds[1] = eff_size(cfg_r[ctsi_pkg::CFG_DST_Y]);
    ds[2] = eff_size(cfg_r[ctsi_pkg::CFG_DST_Z]);
    ss[0] = eff_size(cfg_r[ctsi_pkg::CFG_SRC_X]);
    ss[1] = eff_size(cfg_r[ctsi_pkg::CFG_SRC_Y]);
    ss[2] = eff_size(cfg_r[ctsi_pkg::CFG_SRC_Z]);
  end

  // ---------------- input handshake ----------------
  logic              en;
  logic              skid_valid_r;
  logic              map_acc, load_acc, pend_dec;
  logic [PEND_W-1:0] pend_r;
  logic              b_valid_r;

  assign en       = !skid_valid_r;
  // hold a load until every map ahead of it has read the table
  assign in_ready = (in_data.req_type == ctsi_pkg::REQ_MAP) ? en : (pend_r == '0);
  assign map_acc  = in_valid && in_ready && (in_data.req_type == ctsi_pkg::REQ_MAP);
  assign load_acc = in_valid && in_ready && (in_data.req_type == ctsi_pkg::REQ_LOAD);
  assign pend_dec = en && b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + PEND_W'(map_acc) - PEND_W'(pend_dec);
    end
  end

  // ---------------- index split ----------------
  logic              v1, v2, v3;
  logic [VW-1:0]     q1, q2, q3;
  logic [EW-1:0]     r1, r2, r3;
  logic [VW-1:0]     sd1;
  logic [VW+CB-1:0]  sd2;
  logic [VW+2*CB-1:0] sd3;

  ctsi_div #(.NUM_W(VW), .DEN_W(EW), .SIDE_W(VW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(map_acc),
    .in_num(in_data.dst_voxel), .in_den(ds[0]), .in_side(in_data.dst_voxel),
    .out_valid(v1), .out_quo(q1), .out_rem(r1), .out_side(sd1)
  );

  ctsi_div #(.NUM_W(VW), .DEN_W(EW), .SIDE_W(VW+CB)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1),
    .in_num(q1), .in_den(ds[1]), .in_side({sd1, CB'(r1)}),
    .out_valid(v2), .out_quo(q2), .out_rem(r2), .out_side(sd2)
  );

  ctsi_div #(.NUM_W(VW), .DEN_W(EW), .SIDE_W(VW+2*CB)) u_div_z (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2),
    .in_num(q2), .in_den(ds[2]), .in_side({sd2[VW+CB-1:CB], CB'(r2), sd2[CB-1:0]}),
    .out_valid(v3), .out_quo(q3), .out_rem(r3), .out_side(sd3)
  );

  logic [S1W-1:0] s1_side;
  logic [CB-1:0]  c1 [3];

  // layout: dst, z, y, x with x lowest
  assign s1_side = {sd3[VW+2*CB-1:2*CB], CB'(r3), sd3[2*CB-1:0]};
  assign c1[0]   = s1_side[CB-1:0];
  assign c1[1]   = s1_side[2*CB-1:CB];
  assign c1[2]   = s1_side[3*CB-1:2*CB];

  // ---------------- tetrahedron words ----------------
  logic [ctsi_pkg::COEF_W-1:0] w0 [ctsi_pkg::N_WORD];
  logic [ctsi_pkg::COEF_W-1:0] wt [ctsi_pkg::N_WORD];
  logic [ctsi_pkg::TET_W-1:0]  b_t_r;

  ctsi_tab u_tab (
    .clk(clk), .we(load_acc), .slot(in_data.coef_slot), .wdata(in_data.coef_value),
    .rd_tet(b_t_r), .w0(w0), .wt(wt)
  );

  // ---------------- first pass: centre tetrahedron ----------------
  logic              a_valid;
  logic signed [LW-1:0] lam1 [4];
  logic [S1W-1:0]    a_side;

  ctsi_bary #(.CW(CB), .SIDE_W(S1W)) u_bary0 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3), .in_c(c1), .in_w(w0),
    .in_side(s1_side), .out_valid(a_valid), .out_lam(lam1), .out_side(a_side)
  );

  logic signed [LW-1:0]        min_v;
  logic [1:0]                  min_k;
  logic [ctsi_pkg::TET_W-1:0]  t_nxt;
  logic [S1W-1:0]              b_side_r;

  // first strict minimum; remap only if it is negative
  always_comb begin
    min_v = lam1[0];
    min_k = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (lam1[k] < min_v) begin
        min_v = lam1[k];
        min_k = 2'(k);
      end
    end
    t_nxt = (min_v >= 0) ? '0 : ctsi_pkg::TET_W'(min_k) + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_t_r    <= t_nxt;
      b_side_r <= a_side;
    end
  end

  // ---------------- second pass: chosen tetrahedron ----------------
  logic [CB-1:0]        c2 [3];
  logic                 e_in_valid;
  logic signed [LW-1:0] lam2 [4];
  logic [S1W+2:0]       side2;
  logic [ctsi_pkg::TET_W-1:0] t2;

  assign c2[0] = b_side_r[CB-1:0];
  assign c2[1] = b_side_r[2*CB-1:CB];
  assign c2[2] = b_side_r[3*CB-1:2*CB];

  ctsi_bary #(.CW(CB), .SIDE_W(S1W+3)) u_bary1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_valid_r), .in_c(c2), .in_w(wt),
    .in_side({b_side_r, b_t_r}), .out_valid(e_in_valid), .out_lam(lam2), .out_side(side2)
  );

  assign t2 = side2[ctsi_pkg::TET_W-1:0];

  // ---------------- outside test and axis sums ----------------
  ctsi_pkg::tet_verts_t tv;
  logic                 outside_nxt;
  logic signed [SW-1:0] sum_nxt [3];
  logic                 e_valid_r, e_out_r;
  logic [VW-1:0]        e_dst_r;
  logic signed [SW-1:0] e_sum_r [3];

  always_comb begin
    tv          = ctsi_pkg::tet_verts(t2);
    outside_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (lam2[k] < LW'(-ctsi_pkg::EPS_Q)) begin
        outside_nxt = 1'b1;
      end
    end
    for (int d = 0; d < 3; d++) begin
      sum_nxt[d] = '0;
      for (int k = 0; k < 4; k++) begin
        if (tv[k][d]) begin
          sum_nxt[d] = sum_nxt[d] + SW'(lam2[k]);
        end
      end
    end
  end

  // ---------------- scale by source size ----------------
  logic [ctsi_pkg::FRAC_W:0]       sc [3];
  logic [ctsi_pkg::FRAC_W+EW:0]    prod [3];
  logic [EW-1:0]                   p_nxt [3];
  logic                            f_valid_r, f_out_r;
  logic [VW-1:0]                   f_dst_r;
  logic [EW-1:0]                   f_p_r [3];
  logic [2*EW-1:0]                 f_stride_r;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      if (e_sum_r[d] < 0) begin
        sc[d] = '0;
      end else if (e_sum_r[d] > SW'(ctsi_pkg::Q_ONE)) begin
        sc[d] = (ctsi_pkg::FRAC_W+1)'(ctsi_pkg::Q_ONE);
      end else begin
        sc[d] = e_sum_r[d][ctsi_pkg::FRAC_W:0];
      end
      prod[d]  = (ctsi_pkg::FRAC_W+EW+1)'(sc[d]) * (ctsi_pkg::FRAC_W+EW+1)'(ss[d]);
      p_nxt[d] = prod[d][ctsi_pkg::FRAC_W +: EW];
    end
  end

  // ---------------- clamp and strides ----------------
  logic [CB-1:0]      pc [3];
  logic               g_valid_r, g_out_r;
  logic [VW-1:0]      g_dst_r;
  logic [CB-1:0]      g_pc0_r;
  logic [CB+EW-1:0]   g_m1_r;
  logic [CB+2*EW-1:0] g_m2_r;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      pc[d] = (f_p_r[d] > ss[d] - EW'(1)) ? CB'(ss[d] - EW'(1)) : CB'(f_p_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= e_in_valid;
      f_valid_r <= e_valid_r;
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_out_r    <= outside_nxt;
      e_dst_r    <= side2[S1W+2:S1W+3-VW];
      f_out_r    <= e_out_r;
      f_dst_r    <= e_dst_r;
      f_stride_r <= (2*EW)'(ss[0]) * (2*EW)'(ss[1]);
      g_out_r    <= f_out_r;
      g_dst_r    <= f_dst_r;
      g_pc0_r    <= pc[0];
      g_m1_r     <= (CB+EW)'(pc[1]) * (CB+EW)'(ss[0]);
      g_m2_r     <= (CB+2*EW)'(pc[2]) * (CB+2*EW)'(f_stride_r);
      for (int d = 0; d < 3; d++) begin
        e_sum_r[d] <= sum_nxt[d];
        f_p_r[d]   <= p_nxt[d];
      end
    end
  end

  // ---------------- output register and skid ----------------
  ctsi_pkg::out_t fin;
  logic           fin_valid;
  ctsi_pkg::out_t out_nxt, skid_r, skid_nxt;
  logic           out_valid_nxt, skid_valid_nxt;

  always_comb begin
    fin.dst_index  = g_dst_r;
    fin.src_index  = g_out_r ? '0 : VW'(AW'(g_pc0_r) + AW'(g_m1_r) + AW'(g_m2_r));
    fin.inside_res = !g_out_r;
    fin_valid      = g_valid_r && en;
  end

  always_comb begin
    out_nxt        = out_data;
    out_valid_nxt  = out_valid;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = fin;
        out_valid_nxt = fin_valid;
      end
    end else if (fin_valid) begin
      // park the word while the output is held
      skid_nxt       = fin;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid    <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid    <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt;
    skid_r   <= skid_nxt;
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(PEND_MAX))
    else $error("pending map count beyond pipeline depth");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid)
    else $error("skid word held with empty output register");

  a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_valid && !out_ready) |=> skid_valid_r)
    else $error("skid word dropped while output stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.inside_res) |-> (out_data.src_index == '0))
    else $error("outside word carries a nonzero source index");
`endif

endmodule
